### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg : shared types and codes for the binary min-heap queue
// Field widths, operation and status codes, and the token and write-back
// structures that travel between neighbouring heap level cells.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int KEY_W    = 64;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 11;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [OCC_W-1:0]        occ_type;

   // request operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // result status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // token kinds walking down the level chain
   localparam logic TOK_INSERT = 1'b0;
   localparam logic TOK_SIFT   = 1'b1;

   // token handed from one level cell to the next one down
   typedef struct packed {
      logic    valid;
      logic    kind;
      key_type key;
   } tok_type;

   // write-back from a level cell into the level above it
   typedef struct packed {
      logic    valid;
      key_type key;
   } wu_type;

endpackage

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram : generic single-write, dual-read RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // storage and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/bmhq_cell.sv
// ----------------------------------------------------------------------------
// bmhq_cell : one level of the heap
// Holds every key of one tree level in a small RAM. An insert token is
// compared with the key on its path and the larger one carries on down.
// A sift token names a parent in the level above; the cell reads both
// children, picks the smaller (left on a tie) and either pulls it up into
// the parent slot and passes the moving key on (the last level writes it
// into the child's slot), or drops the moving key into the parent slot and finishes.
// ----------------------------------------------------------------------------
module bmhq_cell #(
   parameter int  LVL    = 0,
   parameter int  LEVELS = 2,
   parameter int  DEPTH  = 1,
   localparam int IDX_W  = LEVELS - 1,
   localparam int TLW    = $clog2(LEVELS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   // token from the level above
   input  bmhq_pkg::tok_type        tok_i,
   input  logic [IDX_W-1:0]         tok_idx_i,
   // token to the level below
   output bmhq_pkg::tok_type        tok_o,
   output logic [IDX_W-1:0]         tok_idx_o,
   // write-back from the level below into this level
   input  bmhq_pkg::wu_type         wu_i,
   input  logic [IDX_W-1:0]         wu_idx_i,
   // write-back from this level into the level above
   output bmhq_pkg::wu_type         wu_o,
   output logic [IDX_W-1:0]         wu_idx_o,
   // broadcast from the controller
   input  logic                     fetch_i,
   input  logic [TLW-1:0]           tail_lvl_i,
   input  logic [IDX_W-1:0]         tail_idx_i,
   // raw read data, used by the controller during a fetch
   output bmhq_pkg::key_type        rd_a_o,
   output bmhq_pkg::key_type        rd_b_o,
   output logic                     done_o
);

   localparam int  AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam bit  IS_LAST = (LVL == LEVELS - 1);

   logic [IDX_W-1:0]          rd_idx_a;
   logic [IDX_W-1:0]          rd_idx_b;
   logic                      fetch_hit;
   logic [bmhq_pkg::KEY_W-1:0] q_a;
   logic [bmhq_pkg::KEY_W-1:0] q_b;

   logic                      hold_valid_ff;
   logic                      hold_kind_ff;
   logic [IDX_W-1:0]          hold_idx_ff;
   bmhq_pkg::key_type         hold_key_ff;

   bmhq_pkg::tok_type         tok_ff;
   bmhq_pkg::tok_type         tok_in;
   logic [IDX_W-1:0]          tok_idx_ff;
   logic [IDX_W-1:0]          tok_idx_in;

   logic                      at_tail;
   logic                      above_tail;
   logic [IDX_W-1:0]          left_idx;
   logic [IDX_W-1:0]          right_idx;
   logic                      left_ok;
   logic                      right_ok;
   logic                      pick_right;
   bmhq_pkg::key_type         pick_key;
   logic [IDX_W-1:0]          pick_idx;
   logic [TLW-1:0]            path_sh;
   logic [IDX_W-1:0]          path_bits;

   logic                      own_we;
   logic [IDX_W-1:0]          own_idx;
   bmhq_pkg::key_type         own_key;
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [bmhq_pkg::KEY_W-1:0] ram_wdata;

   // read addresses: fetch probe, both children of a parent, or the path slot
   always_comb begin
      fetch_hit = fetch_i && (tail_lvl_i == TLW'(LVL));
      if (fetch_i) begin
         rd_idx_a = fetch_hit ? tail_idx_i : '0;
         rd_idx_b = '0;
      end else if (tok_i.kind == bmhq_pkg::TOK_SIFT) begin
         rd_idx_a = IDX_W'({tok_idx_i, 1'b0});
         rd_idx_b = IDX_W'({tok_idx_i, 1'b1});
      end else begin
         rd_idx_a = tok_idx_i;
         rd_idx_b = tok_idx_i;
      end
   end

   // token held while the RAM read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= tok_i.valid;
      end
      if (tok_i.valid) begin
         hold_kind_ff <= tok_i.kind;
         hold_idx_ff  <= tok_idx_i;
         hold_key_ff  <= tok_i.key;
      end
   end

   // compare and steer
   always_comb begin
      at_tail    = (tail_lvl_i == TLW'(LVL));
      above_tail = (TLW'(LVL) < tail_lvl_i);
      left_idx   = IDX_W'({hold_idx_ff, 1'b0});
      right_idx  = IDX_W'({hold_idx_ff, 1'b1});
      left_ok    = above_tail || (at_tail && (left_idx < tail_idx_i));
      right_ok   = above_tail || (at_tail && (right_idx < tail_idx_i));
      pick_right = right_ok && ($signed(q_b) < $signed(q_a));
      pick_key   = pick_right ? $signed(q_b) : $signed(q_a);
      pick_idx   = pick_right ? right_idx : left_idx;
      path_sh    = tail_lvl_i - TLW'(LVL) - TLW'(1);
      path_bits  = tail_idx_i >> path_sh;

      own_we     = 1'b0;
      own_idx    = hold_idx_ff;
      own_key    = hold_key_ff;
      wu_o       = '0;
      wu_idx_o   = hold_idx_ff;
      tok_in     = '0;
      tok_idx_in = '0;
      done_o     = 1'b0;

      if (hold_valid_ff) begin
         if (hold_kind_ff == bmhq_pkg::TOK_INSERT) begin
            if (at_tail) begin
               // free slot reached: the carried key lands here
               own_we = 1'b1;
               done_o = 1'b1;
            end else begin
               tok_in.valid = !IS_LAST;
               tok_in.kind  = bmhq_pkg::TOK_INSERT;
               if (hold_key_ff < $signed(q_a)) begin
                  own_we     = 1'b1;
                  tok_in.key = $signed(q_a);
               end else begin
                  tok_in.key = hold_key_ff;
               end
               tok_idx_in = IDX_W'({hold_idx_ff, path_bits[0]});
            end
         end else begin
            wu_o.valid = 1'b1;
            if (left_ok && (pick_key < hold_key_ff)) begin
               // smaller child moves up, moving key goes on down
               wu_o.key = pick_key;
               if (IS_LAST) begin
                  own_we  = 1'b1;
                  own_idx = pick_idx;
                  done_o  = 1'b1;
               end else begin
                  tok_in.valid = 1'b1;
                  tok_in.kind  = bmhq_pkg::TOK_SIFT;
                  tok_in.key   = hold_key_ff;
                  tok_idx_in   = pick_idx;
               end
            end else begin
               wu_o.key = hold_key_ff;
               done_o   = 1'b1;
            end
         end
      end
   end

   // outgoing token register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.kind <= tok_in.kind;
      tok_ff.key  <= tok_in.key;
      tok_idx_ff  <= tok_idx_in;
   end

   assign tok_o     = tok_ff;
   assign tok_idx_o = tok_idx_ff;

   // write port: the level below has priority, the two never coincide
   always_comb begin
      ram_we = wu_i.valid || own_we;
      if (wu_i.valid) begin
         ram_waddr = AW'(wu_idx_i);
         ram_wdata = wu_i.key;
      end else begin
         ram_waddr = AW'(own_idx);
         ram_wdata = own_key;
      end
   end

   bmhq_ram #(
      .WIDTH (bmhq_pkg::KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (AW'(rd_idx_a)),
      .rd_data_a (q_a),
      .rd_addr_b (AW'(rd_idx_b)),
      .rd_data_b (q_b)
   );

   assign rd_a_o = $signed(q_a);
   assign rd_b_o = $signed(q_b);

endmodule

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue : priority queue of signed 64-bit keys
// Binary min-heap spread over a chain of level cells, one RAM per tree level.
// ----------------------------------------------------------------------------
// One request is worked on at a time. An insert walks a token from the root
// level down to the level of the next free slot; at each level the RAM is
// read, then the keys are compared and written. A removal first reads the
// root and the last key, then walks a sift token down from the first level
// in the same way. The chain has LEVELS = clog2(HEAP_DEPTH+1) levels. Removal
// from an empty heap and insert into a full heap are flagged and answered at
// once with the heap untouched. A finished result sits in an output register
// and a holding register; a new request is taken while the result waits in
// the output register, but not while the holding register is still full.
// The heap RAMs need no clearing after reset.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  bmhq_pkg::key_type      req_key_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmhq_pkg::key_type      rsp_key_out,
   output bmhq_pkg::status_type   rsp_status,
   output bmhq_pkg::occ_type      rsp_occupancy
);

   localparam int LEVELS = $clog2(HEAP_DEPTH + 1);
   localparam int IDX_W  = LEVELS - 1;
   localparam int TLW    = $clog2(LEVELS + 1);
   localparam int LVW    = $clog2(LEVELS);
   localparam int CW     = $clog2(HEAP_DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;
   localparam logic [1:0] ST_RUN   = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [TLW-1:0]           tl_ff, tl_in;
   logic [IDX_W-1:0]         ti_ff, ti_in;
   logic                     op_ff, op_in;
   bmhq_pkg::tok_type        ins_tok_ff, ins_tok_in;
   bmhq_pkg::tok_type        sift_tok_ff, sift_tok_in;
   logic                     res_pend_ff, res_pend_in;
   bmhq_pkg::key_type        res_key_ff, res_key_in;
   bmhq_pkg::status_type     res_status_ff, res_status_in;
   bmhq_pkg::occ_type        res_occ_ff, res_occ_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::key_type        rsp_key_ff, rsp_key_in;
   bmhq_pkg::status_type     rsp_status_ff, rsp_status_in;
   bmhq_pkg::occ_type        rsp_occ_ff, rsp_occ_in;

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   logic                     fetch;
   logic                     any_done;
   logic [IDX_W:0]           tail_sum;
   logic [IDX_W:0]           lvl_span;
   logic [IDX_W-1:0]         lvl_last;
   bmhq_pkg::key_type        last_key;

   bmhq_pkg::tok_type        tok_o    [LEVELS];
   logic [IDX_W-1:0]         tok_idx_o [LEVELS];
   bmhq_pkg::wu_type         wu_o     [LEVELS];
   logic [IDX_W-1:0]         wu_idx_o [LEVELS];
   bmhq_pkg::key_type        rd_a     [LEVELS];
   bmhq_pkg::key_type        rd_b     [LEVELS];
   logic [LEVELS-1:0]        done_vec;

   assign req_stall = (state_ff != ST_IDLE) || res_pend_ff;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CW'(HEAP_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign fetch     = (state_ff == ST_FETCH);
   assign any_done  = |done_vec;
   assign last_key  = rd_a[tl_ff[LVW-1:0]];

   // next-free-slot arithmetic (level, index within level)
   assign tail_sum = {1'b0, ti_ff} + (IDX_W+1)'(1);
   assign lvl_span = (IDX_W+1)'(1) << tl_ff;
   assign lvl_last = IDX_W'(((IDX_W+1)'(1) << (tl_ff - TLW'(1))) - (IDX_W+1)'(1));

   // control sequencer and result path
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tl_in         = tl_ff;
      ti_in         = ti_ff;
      op_in         = op_ff;
      ins_tok_in    = '0;
      sift_tok_in   = '0;
      res_pend_in   = res_pend_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      res_occ_in    = res_occ_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      // output register: refill from the holding register on a free slot
      if (res_pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = res_key_ff;
         rsp_status_in = res_status_ff;
         rsp_occ_in    = res_occ_ff;
         res_pend_in   = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_func;
               if (req_func == bmhq_pkg::FUNC_INSERT) begin
                  res_key_in  = req_key_in;
                  res_pend_in = 1'b1;
                  if (is_full) begin
                     res_status_in = bmhq_pkg::STATUS_FULL;
                     res_occ_in    = bmhq_pkg::OCC_W'(count_ff);
                  end else begin
                     res_status_in    = bmhq_pkg::STATUS_OK;
                     count_in         = count_ff + CW'(1);
                     res_occ_in       = bmhq_pkg::OCC_W'(count_ff + CW'(1));
                     ins_tok_in.valid = 1'b1;
                     ins_tok_in.kind  = bmhq_pkg::TOK_INSERT;
                     ins_tok_in.key   = req_key_in;
                     state_in         = ST_RUN;
                  end
               end else begin
                  if (is_empty) begin
                     res_key_in    = '0;
                     res_status_in = bmhq_pkg::STATUS_EMPTY;
                     res_occ_in    = '0;
                     res_pend_in   = 1'b1;
                  end else begin
                     count_in      = count_ff - CW'(1);
                     res_status_in = bmhq_pkg::STATUS_OK;
                     res_occ_in    = bmhq_pkg::OCC_W'(count_ff - CW'(1));
                     // the slot given up is where the last key lives
                     if (ti_ff == '0) begin
                        tl_in = tl_ff - TLW'(1);
                        ti_in = lvl_last;
                     end else begin
                        ti_in = ti_ff - IDX_W'(1);
                     end
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // root goes out, last key starts its way down from the top
            res_key_in        = rd_b[0];
            res_pend_in       = 1'b1;
            sift_tok_in.valid = 1'b1;
            sift_tok_in.kind  = bmhq_pkg::TOK_SIFT;
            sift_tok_in.key   = last_key;
            state_in          = ST_RUN;
         end
         ST_RUN: begin
            if (any_done) begin
               state_in = ST_IDLE;
               if (op_ff == bmhq_pkg::FUNC_INSERT) begin
                  if (tail_sum == lvl_span) begin
                     tl_in = tl_ff + TLW'(1);
                     ti_in = '0;
                  end else begin
                     ti_in = tail_sum[IDX_W-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         count_ff          <= '0;
         tl_ff             <= '0;
         ti_ff             <= '0;
         ins_tok_ff.valid  <= 1'b0;
         sift_tok_ff.valid <= 1'b0;
         res_pend_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         tl_ff             <= tl_in;
         ti_ff             <= ti_in;
         ins_tok_ff.valid  <= ins_tok_in.valid;
         sift_tok_ff.valid <= sift_tok_in.valid;
         res_pend_ff       <= res_pend_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      op_ff            <= op_in;
      ins_tok_ff.kind  <= ins_tok_in.kind;
      ins_tok_ff.key   <= ins_tok_in.key;
      sift_tok_ff.kind <= sift_tok_in.kind;
      sift_tok_ff.key  <= sift_tok_in.key;
      res_key_ff       <= res_key_in;
      res_status_ff    <= res_status_in;
      res_occ_ff       <= res_occ_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_occ_ff       <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // chain of level cells, root level first
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam int LVL_DEPTH = (l == LEVELS - 1) ? HEAP_DEPTH - (2**l - 1) : 2**l;

      bmhq_pkg::tok_type   cell_tok;
      logic [IDX_W-1:0]    cell_tok_idx;
      bmhq_pkg::wu_type    cell_wu;
      logic [IDX_W-1:0]    cell_wu_idx;

      if (l == 0) begin : g_root
         assign cell_tok     = ins_tok_ff;
         assign cell_tok_idx = '0;
      end else if (l == 1) begin : g_first
         // sift tokens enter here with the root as their parent
         assign cell_tok     = tok_o[0].valid ? tok_o[0] : sift_tok_ff;
         assign cell_tok_idx = tok_o[0].valid ? tok_idx_o[0] : '0;
      end else begin : g_inner
         assign cell_tok     = tok_o[l-1];
         assign cell_tok_idx = tok_idx_o[l-1];
      end

      if (l < LEVELS - 1) begin : g_wu
         assign cell_wu     = wu_o[l+1];
         assign cell_wu_idx = wu_idx_o[l+1];
      end else begin : g_wu_end
         assign cell_wu     = '0;
         assign cell_wu_idx = '0;
      end

      bmhq_cell #(
         .LVL    (l),
         .LEVELS (LEVELS),
         .DEPTH  (LVL_DEPTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_i      (cell_tok),
         .tok_idx_i  (cell_tok_idx),
         .tok_o      (tok_o[l]),
         .tok_idx_o  (tok_idx_o[l]),
         .wu_i       (cell_wu),
         .wu_idx_i   (cell_wu_idx),
         .wu_o       (wu_o[l]),
         .wu_idx_o   (wu_idx_o[l]),
         .fetch_i    (fetch),
         .tail_lvl_i (tl_ff),
         .tail_idx_i (ti_ff),
         .rd_a_o     (rd_a[l]),
         .rd_b_o     (rd_b[l]),
         .done_o     (done_vec[l])
      );
   end

endmodule

### rtl/bmhq_check.sv
// ----------------------------------------------------------------------------
// bmhq_check : port-level checks for the binary min-heap queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_check #(
   parameter int HEAP_DEPTH = 1024
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   req_func,
   input bmhq_pkg::key_type      req_key_in,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bmhq_pkg::key_type      rsp_key_out,
   input bmhq_pkg::status_type   rsp_status,
   input bmhq_pkg::occ_type      rsp_occupancy
);

   // only defined status codes leave the block
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bmhq_pkg::STATUS_OK) ||
                    (rsp_status == bmhq_pkg::STATUS_EMPTY) ||
                    (rsp_status == bmhq_pkg::STATUS_FULL))
      else $error("undefined status code on result");

   // an empty removal reports nothing held and a zero key
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bmhq_pkg::STATUS_EMPTY) |->
         (rsp_occupancy == '0) && (rsp_key_out == '0))
      else $error("empty removal with non-zero key or occupancy");

   // a refused insert reports a full heap
   a_full_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bmhq_pkg::STATUS_FULL) |->
         rsp_occupancy == bmhq_pkg::OCC_W'(HEAP_DEPTH))
      else $error("full status with wrong occupancy");

   // the cycle after an accepted request always has the input held off
   a_req_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back-to-back cycles");

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out) &&
         $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled result changed");

endmodule

bind binary_min_heap_queue bmhq_check #(.HEAP_DEPTH(HEAP_DEPTH)) u_bmhq_check (.*);
